@@ rtl/deq_pkg.sv @@
// ----------------------------------------------------------------------------
// Double-ended queue package
// Sizes, element types, action and status codes and index wrap helpers.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEPTH  = 64;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ELEM_W = 32;
  localparam int ACT_W  = 3;
  localparam int STAT_W = 2;

  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic [CNT_W-1:0]          cnt_t;
  typedef logic signed [ELEM_W-1:0]  elem_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_REAR  = 3'd0,
    ACT_PUSH_FRONT = 3'd1,
    ACT_POP_REAR   = 3'd2,
    ACT_POP_FRONT  = 3'd3,
    ACT_LIST       = 3'd4
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  function automatic idx_t idx_inc(idx_t i);
    return (i == idx_t'(DEPTH - 1)) ? '0 : idx_t'(i + idx_t'(1));
  endfunction

  function automatic idx_t idx_dec(idx_t i);
    return (i == '0) ? idx_t'(DEPTH - 1) : idx_t'(i - idx_t'(1));
  endfunction

endpackage

@@ rtl/deq_in_if.sv @@
// ----------------------------------------------------------------------------
// Double-ended queue request channel
// Valid/ready channel carrying one action and its value per transfer.
// ----------------------------------------------------------------------------
interface deq_in_if;
  logic                        valid;
  logic                        ready;
  logic [deq_pkg::ACT_W-1:0]   action;
  deq_pkg::elem_t              value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

@@ rtl/deq_out_if.sv @@
// ----------------------------------------------------------------------------
// Double-ended queue result channel
// Valid/ready channel carrying status, element and end-of-run flag.
// ----------------------------------------------------------------------------
interface deq_out_if;
  logic                        valid;
  logic                        ready;
  logic [deq_pkg::STAT_W-1:0]  status;
  deq_pkg::elem_t              element;
  logic                        last_of_run;

  modport source (output valid, output status, output element, output last_of_run,
                  input ready);
  modport sink   (input valid, input status, input element, input last_of_run,
                  output ready);
endinterface

@@ rtl/double_ended_queue_core.sv @@
// ----------------------------------------------------------------------------
// Double-ended queue core
// Bounded deque of signed 32-bit values in a circular on-chip store.
//
//   channel  | dir | payload                        | handshake
//   in_ch    | in  | action, value                  | valid/ready
//   out_ch   | out | status, element, last_of_run   | valid/ready
//
// Push and any empty/full status: the result register loads on acceptance.
// Pop: the registered store read feeds the result register from the wait state.
// List: one store read and one transfer per cycle unless the result stalls.
// Reset clears head, tail, count and the result valid flag; the store is not
// cleared and needs no sweep. A stalled result holds and blocks the sequence.
// ----------------------------------------------------------------------------
module double_ended_queue_core (
  input  logic      clk,
  input  logic      rst,
  deq_in_if.sink    in_ch,
  deq_out_if.source out_ch
);

  logic                           ram_we;
  deq_pkg::idx_t                  ram_waddr;
  logic [deq_pkg::ELEM_W-1:0]     ram_wdata;
  logic                           ram_re;
  deq_pkg::idx_t                  ram_raddr;
  logic [deq_pkg::ELEM_W-1:0]     ram_rdata;

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  deq_ram #(
    .WIDTH (deq_pkg::ELEM_W),
    .DEPTH (deq_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

@@ rtl/deq_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/deq_ctrl.sv @@
// ----------------------------------------------------------------------------
// Double-ended queue controller
// Head, tail and count registers, request decode, read sequencing for pops
// and listing, and the result output register.
// ----------------------------------------------------------------------------
module deq_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  deq_in_if.sink                in_ch,
  deq_out_if.source             out_ch,
  output logic                  ram_we,
  output deq_pkg::idx_t         ram_waddr,
  output logic [deq_pkg::ELEM_W-1:0] ram_wdata,
  output logic                  ram_re,
  output deq_pkg::idx_t         ram_raddr,
  input  logic [deq_pkg::ELEM_W-1:0] ram_rdata
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WAIT = 2'b10
  } state_t;

  state_t          state, state_next;
  deq_pkg::idx_t   head, head_next;
  deq_pkg::idx_t   tail, tail_next;
  deq_pkg::cnt_t   count, count_next;
  deq_pkg::cnt_t   remain, remain_next;
  deq_pkg::idx_t   lidx, lidx_next;

  logic            out_valid;
  deq_pkg::status_t out_status;
  deq_pkg::elem_t  out_element;
  logic            out_last;

  logic            out_free;
  logic            accept;
  logic            is_full;
  logic            is_empty;
  logic            load_out;
  deq_pkg::status_t load_status;
  deq_pkg::elem_t  load_element;
  logic            load_last;

  assign out_free = !out_valid || out_ch.ready;
  assign in_ch.ready = (state == S_IDLE) && out_free;
  assign accept = in_ch.valid && in_ch.ready;
  assign is_full = (count == deq_pkg::cnt_t'(deq_pkg::DEPTH));
  assign is_empty = (count == '0);
  assign ram_wdata = in_ch.value;

  always_comb begin
    state_next   = state;
    head_next    = head;
    tail_next    = tail;
    count_next   = count;
    remain_next  = remain;
    lidx_next    = lidx;
    ram_we       = 1'b0;
    ram_waddr    = tail;
    ram_re       = 1'b0;
    ram_raddr    = head;
    load_out     = 1'b0;
    load_status  = deq_pkg::STAT_OK;
    load_element = '0;
    load_last    = 1'b1;

    case (state)
      S_IDLE: begin
        if (accept) begin
          case (deq_pkg::action_t'(in_ch.action))
            deq_pkg::ACT_PUSH_REAR: begin
              load_out = 1'b1;
              if (is_full) begin
                load_status = deq_pkg::STAT_FULL;
              end else begin
                ram_we     = 1'b1;
                ram_waddr  = tail;
                tail_next  = deq_pkg::idx_inc(tail);
                count_next = deq_pkg::cnt_t'(count + deq_pkg::cnt_t'(1));
              end
            end
            deq_pkg::ACT_PUSH_FRONT: begin
              load_out = 1'b1;
              if (is_full) begin
                load_status = deq_pkg::STAT_FULL;
              end else begin
                ram_we     = 1'b1;
                ram_waddr  = deq_pkg::idx_dec(head);
                head_next  = deq_pkg::idx_dec(head);
                count_next = deq_pkg::cnt_t'(count + deq_pkg::cnt_t'(1));
              end
            end
            deq_pkg::ACT_POP_REAR: begin
              if (is_empty) begin
                load_out    = 1'b1;
                load_status = deq_pkg::STAT_EMPTY;
              end else begin
                ram_re      = 1'b1;
                ram_raddr   = deq_pkg::idx_dec(tail);
                tail_next   = deq_pkg::idx_dec(tail);
                count_next  = deq_pkg::cnt_t'(count - deq_pkg::cnt_t'(1));
                remain_next = deq_pkg::cnt_t'(1);
                state_next  = S_WAIT;
              end
            end
            deq_pkg::ACT_POP_FRONT: begin
              if (is_empty) begin
                load_out    = 1'b1;
                load_status = deq_pkg::STAT_EMPTY;
              end else begin
                ram_re      = 1'b1;
                ram_raddr   = head;
                head_next   = deq_pkg::idx_inc(head);
                count_next  = deq_pkg::cnt_t'(count - deq_pkg::cnt_t'(1));
                remain_next = deq_pkg::cnt_t'(1);
                state_next  = S_WAIT;
              end
            end
            deq_pkg::ACT_LIST: begin
              if (is_empty) begin
                load_out    = 1'b1;
                load_status = deq_pkg::STAT_EMPTY;
              end else begin
                ram_re      = 1'b1;
                ram_raddr   = head;
                lidx_next   = deq_pkg::idx_inc(head);
                remain_next = count;
                state_next  = S_WAIT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_WAIT: begin
        // hold read data until the output register frees
        if (out_free) begin
          load_out     = 1'b1;
          load_element = deq_pkg::elem_t'(ram_rdata);
          load_last    = (remain == deq_pkg::cnt_t'(1));
          if (remain == deq_pkg::cnt_t'(1)) begin
            state_next = S_IDLE;
          end else begin
            ram_re      = 1'b1;
            ram_raddr   = lidx;
            lidx_next   = deq_pkg::idx_inc(lidx);
            remain_next = deq_pkg::cnt_t'(remain - deq_pkg::cnt_t'(1));
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      remain    <= '0;
      lidx      <= '0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      head   <= head_next;
      tail   <= tail_next;
      count  <= count_next;
      remain <= remain_next;
      lidx   <= lidx_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status  <= load_status;
      out_element <= load_element;
      out_last    <= load_last;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.status      = out_status;
  assign out_ch.element     = out_element;
  assign out_ch.last_of_run = out_last;

endmodule

@@ rtl/deq_checker.sv @@
// ----------------------------------------------------------------------------
// Double-ended queue port checker
// Port-level checks on request and result transfers, bound to the core.
// ----------------------------------------------------------------------------
module deq_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [deq_pkg::ACT_W-1:0]   in_action,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [deq_pkg::STAT_W-1:0]  out_status,
  input deq_pkg::elem_t              out_element,
  input logic                        out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_element) && $stable(out_last))
    else $error("result changed while stalled");

  a_push_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_action == deq_pkg::ACT_PUSH_REAR
      || in_action == deq_pkg::ACT_PUSH_FRONT)
    |=> out_valid && out_last && out_element == '0
      && out_status != deq_pkg::STAT_EMPTY)
    else $error("push did not give a single result");

  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != deq_pkg::STAT_OK |-> out_element == '0 && out_last)
    else $error("status result carries an element");

  a_run_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> !in_ready)
    else $error("request taken during a listing run");

endmodule

bind double_ended_queue_core deq_checker u_deq_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_action   (in_ch.action),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_status  (out_ch.status),
  .out_element (out_ch.element),
  .out_last    (out_ch.last_of_run)
);

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// Double-ended queue core testbench
// Drives push, pop and list requests into the core and checks every result
// transfer. Directed rows cover the empty status, the value extremes, index
// wrap past zero and the unused action codes. A random run then fills the
// queue to capacity with mixed-end pushes, tests full and churns it with
// pop-biased traffic. A behavioural copy of the deque predicts each result.
// The sender works in bursts with gaps and the receiver stalls in modes.
// ----------------------------------------------------------------------------
module tb;
  import deq_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 100;
  localparam int N_DIRECTED   = 21;
  localparam int N_MIX        = 20;

  localparam logic [ACT_W-1:0] ACT_RSVD_LO  = 3'd5;
  localparam logic [ACT_W-1:0] ACT_RSVD_MID = 3'd6;
  localparam logic [ACT_W-1:0] ACT_RSVD_HI  = 3'd7;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    elem_t             element;
    logic              last;
  } deq_result_t;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    elem_t            val;
    logic             typed;
    deq_result_t      res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  deq_in_if  in_ch ();
  deq_out_if out_ch ();

  double_ended_queue_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  elem_t       mirror_store [DEPTH];
  idx_t        mirror_head = '0;
  idx_t        mirror_tail = '0;
  cnt_t        mirror_count = '0;
  deq_result_t awaited_results [$];

  logic        row_typed;
  deq_result_t row_expect;
  stim_row_t   directed_rows [N_DIRECTED];

  int plan_count;
  int burst_left;
  int mismatch_count = 0;
  int cycle_count = 0;
  int stall_mode = 0;
  int stall_run = 0;

  always #4 clk = ~clk;

  function automatic idx_t wrap_up(idx_t i);
    return idx_t'((int'(i) + 1) % DEPTH);
  endfunction

  function automatic idx_t wrap_down(idx_t i);
    return idx_t'((int'(i) + DEPTH - 1) % DEPTH);
  endfunction

  task automatic deque_apply(input logic [ACT_W-1:0] act, input elem_t val);
    idx_t rd;
    case (act)
      ACT_PUSH_REAR, ACT_PUSH_FRONT: begin
        if (mirror_count == cnt_t'(DEPTH)) begin
          awaited_results.push_back('{STAT_FULL, '0, 1'b1});
        end else begin
          if (act == ACT_PUSH_REAR) begin
            mirror_store[mirror_tail] = val;
            mirror_tail = wrap_up(mirror_tail);
          end else begin
            mirror_head = wrap_down(mirror_head);
            mirror_store[mirror_head] = val;
          end
          mirror_count = mirror_count + cnt_t'(1);
          awaited_results.push_back('{STAT_OK, '0, 1'b1});
        end
      end
      ACT_POP_REAR, ACT_POP_FRONT: begin
        if (mirror_count == '0) begin
          awaited_results.push_back('{STAT_EMPTY, '0, 1'b1});
        end else begin
          if (act == ACT_POP_REAR) begin
            mirror_tail = wrap_down(mirror_tail);
            rd = mirror_tail;
          end else begin
            rd = mirror_head;
            mirror_head = wrap_up(mirror_head);
          end
          mirror_count = mirror_count - cnt_t'(1);
          awaited_results.push_back('{STAT_OK, mirror_store[rd], 1'b1});
        end
      end
      ACT_LIST: begin
        if (mirror_count == '0) begin
          awaited_results.push_back('{STAT_EMPTY, '0, 1'b1});
        end else begin
          rd = mirror_head;
          for (int n = 0; n < int'(mirror_count); n++) begin
            awaited_results.push_back('{STAT_OK, mirror_store[rd],
                                        (n + 1 == int'(mirror_count))});
            rd = wrap_up(rd);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic note_mismatch(input string what, input deq_result_t want,
                               input deq_result_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%s: expected status %0d element %0d last %0b, got status %0d element %0d last %0b",
               what, want.status, want.element, want.last,
               got.status, got.element, got.last);
    end
  endtask

  always @(posedge clk) begin
    deq_result_t got;
    deq_result_t want;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        deque_apply(in_ch.action, in_ch.value);
        if (row_typed) begin
          void'(awaited_results.pop_back());
          awaited_results.push_back(row_expect);
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.status, out_ch.element, out_ch.last_of_run};
        if (awaited_results.size() == 0) begin
          note_mismatch("unexpected result", '0, got);
        end else begin
          want = awaited_results.pop_front();
          if (got.status !== want.status || got.element !== want.element ||
              got.last !== want.last) begin
            note_mismatch("result mismatch", want, got);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_mode <= $urandom_range(3, 0);
      stall_run  <= $urandom_range(80, 16);
    end else begin
      stall_run <= stall_run - 1;
    end
    case (stall_mode)
      0:       out_ch.ready <= 1'b1;
      1:       out_ch.ready <= $urandom_range(1, 0);
      2:       out_ch.ready <= ($urandom_range(7, 0) == 0);
      default: out_ch.ready <= ($urandom_range(3, 0) != 0);
    endcase
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [ACT_W-1:0] random_action(int push_w, int pop_w, int list_w);
    int r;
    r = $urandom_range(99, 0);
    if (r < push_w) return $urandom_range(1, 0) ? ACT_PUSH_FRONT : ACT_PUSH_REAR;
    if (r < push_w + pop_w) return $urandom_range(1, 0) ? ACT_POP_FRONT : ACT_POP_REAR;
    if (r < push_w + pop_w + list_w) return ACT_LIST;
    return ACT_W'($urandom_range(ACT_RSVD_HI, ACT_RSVD_LO));
  endfunction

  function automatic elem_t random_value();
    case ($urandom_range(7, 0))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return -32'sd1;
      default: return elem_t'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic [ACT_W-1:0] act, input elem_t val,
                           input logic typed, input deq_result_t res);
    if (burst_left == 0) begin
      repeat ($urandom_range(6, 1)) @(posedge clk);
      burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(40, 20)
                                                : $urandom_range(6, 1);
    end
    in_ch.valid  <= 1'b1;
    in_ch.action <= act;
    in_ch.value  <= val;
    row_typed    <= typed;
    row_expect   <= res;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    if (act == ACT_PUSH_REAR || act == ACT_PUSH_FRONT) begin
      if (plan_count < DEPTH) plan_count++;
    end else if (act == ACT_POP_REAR || act == ACT_POP_FRONT) begin
      if (plan_count > 0) plan_count--;
    end
    burst_left--;
    if (burst_left == 0) in_ch.valid <= 1'b0;
  endtask

  initial begin
    rst            = 1'b1;
    in_ch.valid    = 1'b0;
    in_ch.action   = '0;
    in_ch.value    = '0;
    row_typed      = 1'b0;
    row_expect     = '0;
    plan_count     = 0;
    burst_left     = 0;

    directed_rows = '{
      '{ACT_POP_REAR,   32'sd0,          1'b1, '{STAT_EMPTY, 32'sd0, 1'b1}},
      '{ACT_POP_FRONT,  -32'sd1,         1'b1, '{STAT_EMPTY, 32'sd0, 1'b1}},
      '{ACT_LIST,       32'sd0,          1'b1, '{STAT_EMPTY, 32'sd0, 1'b1}},
      '{ACT_RSVD_LO,    32'sh0000_1234,  1'b0, '0},
      '{ACT_PUSH_REAR,  32'sh7fff_ffff,  1'b1, '{STAT_OK, 32'sd0, 1'b1}},
      '{ACT_PUSH_FRONT, 32'sh8000_0000,  1'b1, '{STAT_OK, 32'sd0, 1'b1}},
      '{ACT_LIST,       32'sd0,          1'b0, '0},
      '{ACT_POP_REAR,   32'sd0,          1'b1, '{STAT_OK, 32'sh7fff_ffff, 1'b1}},
      '{ACT_POP_FRONT,  32'sd0,          1'b1, '{STAT_OK, 32'sh8000_0000, 1'b1}},
      '{ACT_POP_FRONT,  32'sd0,          1'b1, '{STAT_EMPTY, 32'sd0, 1'b1}},
      '{ACT_RSVD_MID,   -32'sd1,         1'b0, '0},
      '{ACT_PUSH_FRONT, 32'sd0,          1'b1, '{STAT_OK, 32'sd0, 1'b1}},
      '{ACT_PUSH_FRONT, -32'sd1,         1'b1, '{STAT_OK, 32'sd0, 1'b1}},
      '{ACT_PUSH_REAR,  32'sd1,          1'b1, '{STAT_OK, 32'sd0, 1'b1}},
      '{ACT_LIST,       32'sd0,          1'b0, '0},
      '{ACT_POP_REAR,   32'sd0,          1'b0, '0},
      '{ACT_RSVD_HI,    32'sh5555_aaaa,  1'b0, '0},
      '{ACT_POP_FRONT,  32'sd0,          1'b0, '0},
      '{ACT_LIST,       32'sd0,          1'b0, '0},
      '{ACT_POP_FRONT,  32'sd0,          1'b0, '0},
      '{ACT_LIST,       32'sd0,          1'b1, '{STAT_EMPTY, 32'sd0, 1'b1}}
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].act, directed_rows[i].val,
                directed_rows[i].typed, directed_rows[i].res);
    end

    while (plan_count < DEPTH) send_item(random_action(95, 0, 5), random_value(), 1'b0, '0);
    send_item(ACT_PUSH_REAR,  random_value(), 1'b1, '{STAT_FULL, 32'sd0, 1'b1});
    send_item(ACT_PUSH_FRONT, random_value(), 1'b1, '{STAT_FULL, 32'sd0, 1'b1});
    send_item(ACT_LIST, elem_t'($urandom), 1'b0, '0);

    repeat (N_MIX) send_item(random_action(25, 50, 15), random_value(), 1'b0, '0);

    if (burst_left != 0) begin
      in_ch.valid <= 1'b0;
      burst_left = 0;
    end

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
